FILE: rtl/hpv_pkg.sv
`default_nettype none

package hpv_pkg;

  // Item field widths.
  localparam int AMP_BITS      = 16;
  localparam int PHASE_IN_BITS = 16;

  // Internal phase resolution: one turn is 2**PHASE_BITS.
  localparam int PHASE_BITS = 16;

  // Harmonics beyond this many in one frame are ignored.
  localparam int MAX_HARMONICS = 64;
  localparam int HARM_LIMIT    = (MAX_HARMONICS < 127) ? MAX_HARMONICS : 127;
  localparam int COUNT_BITS    = 7;

  localparam int SQ_BITS   = 2 * AMP_BITS;
  localparam int FE_BITS   = 40;
  localparam int VOTE_BITS = 18;
  localparam int EBAL_BITS = 56;

  localparam logic [COUNT_BITS-1:0] HARM_LIMIT_C = COUNT_BITS'(HARM_LIMIT);

  localparam logic [PHASE_BITS-1:0] PHASE_QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);
  localparam logic [PHASE_BITS-1:0] PHASE_3QUARTER = PHASE_BITS'(3) << (PHASE_BITS - 2);

  localparam logic signed [VOTE_BITS-1:0] VOTE_MAX = {1'b0, {(VOTE_BITS-1){1'b1}}};
  localparam logic signed [VOTE_BITS-1:0] VOTE_MIN = {1'b1, {(VOTE_BITS-1){1'b0}}};
  localparam logic signed [EBAL_BITS-1:0] EBAL_MAX = {1'b0, {(EBAL_BITS-1){1'b1}}};
  localparam logic signed [EBAL_BITS-1:0] EBAL_MIN = {1'b1, {(EBAL_BITS-1){1'b0}}};

  typedef struct packed {
    logic [AMP_BITS-1:0]      amplitude;
    logic [PHASE_IN_BITS-1:0] phase;
    logic                     voiced;
    logic                     last_harmonic;
    logic                     last_frame;
  } item_t;

  // Summary of one finished frame, handed to the segment vote stage.
  typedef struct packed {
    logic               valid;
    logic               up;
    logic               down;
    logic               last_frame;
    logic [FE_BITS-1:0] energy;
  } frame_rec_t;

  // Sign-extend a raw phase and reduce it modulo one turn.
  function automatic logic [PHASE_BITS-1:0] phase_turns(input logic [PHASE_IN_BITS-1:0] raw);
    logic [PHASE_BITS+PHASE_IN_BITS-1:0] ext;
    ext = {{PHASE_BITS{raw[PHASE_IN_BITS-1]}}, raw};
    return ext[PHASE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/hpv_frame.sv
`default_nettype none

module hpv_frame (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               item_valid,
  input  wire hpv_pkg::item_t     item,
  output hpv_pkg::frame_rec_t     rec
);

  // Square stage.
  logic                          s1_valid;
  hpv_pkg::item_t                s1;
  logic [hpv_pkg::SQ_BITS-1:0]   sq;

  // Frame accumulators.
  logic [hpv_pkg::FE_BITS-1:0]    frame_energy;
  logic [hpv_pkg::COUNT_BITS-1:0] harmonic_count;
  logic [hpv_pkg::PHASE_IN_BITS-1:0] first_phase;
  logic [hpv_pkg::PHASE_IN_BITS-1:0] second_phase;

  logic                             take;
  logic [hpv_pkg::COUNT_BITS-1:0]   count_next;
  logic [hpv_pkg::FE_BITS:0]        fe_sum;
  logic [hpv_pkg::FE_BITS-1:0]      fe_next;
  logic [hpv_pkg::PHASE_IN_BITS-1:0] second_eff;
  logic [hpv_pkg::PHASE_BITS-1:0]   p1;
  logic [hpv_pkg::PHASE_BITS-1:0]   p2;
  logic [hpv_pkg::PHASE_BITS-1:0]   alpha;
  logic                             vote_en;
  logic                             near_zero;
  logic                             near_half;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= item_valid;
    end
    if (en) begin
      s1 <= item;
      sq <= item.amplitude * item.amplitude;
    end
  end

  always_comb begin
    take       = harmonic_count < hpv_pkg::HARM_LIMIT_C;
    count_next = take ? harmonic_count + hpv_pkg::COUNT_BITS'(1) : harmonic_count;
    fe_sum     = {1'b0, frame_energy} + (hpv_pkg::FE_BITS + 1)'(sq);
    if (!take) begin
      fe_next = frame_energy;
    end else if (fe_sum[hpv_pkg::FE_BITS]) begin
      fe_next = '1;
    end else begin
      fe_next = fe_sum[hpv_pkg::FE_BITS-1:0];
    end
    // The second harmonic may arrive on the very item that closes the frame.
    second_eff = (take && harmonic_count == hpv_pkg::COUNT_BITS'(1)) ? s1.phase : second_phase;
    p1         = hpv_pkg::phase_turns(first_phase);
    p2         = hpv_pkg::phase_turns(second_eff);
    alpha      = {p1[hpv_pkg::PHASE_BITS-2:0], 1'b0} - p2;
    near_zero  = (alpha < hpv_pkg::PHASE_QUARTER) || (alpha > hpv_pkg::PHASE_3QUARTER);
    near_half  = (alpha > hpv_pkg::PHASE_QUARTER) && (alpha < hpv_pkg::PHASE_3QUARTER);
    vote_en    = s1.voiced && (count_next >= hpv_pkg::COUNT_BITS'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_energy   <= '0;
      harmonic_count <= '0;
      rec.valid      <= 1'b0;
    end else if (en) begin
      rec.valid <= s1_valid && s1.last_harmonic;
      if (s1_valid) begin
        if (s1.last_harmonic) begin
          frame_energy   <= '0;
          harmonic_count <= '0;
        end else begin
          frame_energy   <= fe_next;
          harmonic_count <= count_next;
        end
      end
    end
    if (en) begin
      rec.up         <= vote_en && near_zero;
      rec.down       <= vote_en && near_half;
      rec.last_frame <= s1.last_frame;
      rec.energy     <= fe_next;
      if (s1_valid && take && harmonic_count == '0) begin
        first_phase <= s1.phase;
      end
      if (s1_valid && take && harmonic_count == hpv_pkg::COUNT_BITS'(1)) begin
        second_phase <= s1.phase;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    harmonic_count <= hpv_pkg::HARM_LIMIT_C)
    else $error("harmonic count beyond limit");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (en && s1_valid && s1.last_harmonic) |=> (harmonic_count == '0 && frame_energy == '0))
    else $error("frame accumulators not cleared at end of frame");

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    rec.valid |-> !(rec.up && rec.down))
    else $error("frame voted both ways");
`endif

endmodule

`default_nettype wire

FILE: rtl/hpv_segment.sv
`default_nettype none

module hpv_segment (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 en,
  input  wire hpv_pkg::frame_rec_t                  rec,
  output logic                                      out_valid,
  output logic                                      inverted,
  output logic signed [hpv_pkg::VOTE_BITS-1:0]      vote_total,
  output logic signed [hpv_pkg::EBAL_BITS-1:0]      energy_total
);

  logic signed [hpv_pkg::VOTE_BITS-1:0] vote_sum;
  logic signed [hpv_pkg::EBAL_BITS-1:0] energy_balance;
  logic signed [hpv_pkg::VOTE_BITS-1:0] vote_next;
  logic signed [hpv_pkg::EBAL_BITS-1:0] ebal_next;
  logic [hpv_pkg::EBAL_BITS:0]          bal_ext;
  logic [hpv_pkg::EBAL_BITS:0]          e_ext;
  logic [hpv_pkg::EBAL_BITS:0]          bal_sum;
  logic                                 bal_ovf;
  logic                                 neg_next;

  always_comb begin
    bal_ext = {energy_balance[hpv_pkg::EBAL_BITS-1], energy_balance};
    e_ext   = (hpv_pkg::EBAL_BITS + 1)'(rec.energy);
    bal_sum = rec.down ? bal_ext - e_ext : bal_ext + e_ext;
    bal_ovf = bal_sum[hpv_pkg::EBAL_BITS] != bal_sum[hpv_pkg::EBAL_BITS-1];

    vote_next = vote_sum;
    ebal_next = energy_balance;
    if (rec.down) begin
      if (vote_sum != hpv_pkg::VOTE_MIN) begin
        vote_next = vote_sum - hpv_pkg::VOTE_BITS'(1);
      end
      ebal_next = bal_ovf ? hpv_pkg::EBAL_MIN : bal_sum[hpv_pkg::EBAL_BITS-1:0];
    end else if (rec.up) begin
      if (vote_sum != hpv_pkg::VOTE_MAX) begin
        vote_next = vote_sum + hpv_pkg::VOTE_BITS'(1);
      end
      ebal_next = bal_ovf ? hpv_pkg::EBAL_MAX : bal_sum[hpv_pkg::EBAL_BITS-1:0];
    end

    // Vote sign decides first, then energy sign; a full tie is positive.
    neg_next = vote_next[hpv_pkg::VOTE_BITS-1] ||
               (vote_next == '0 && ebal_next[hpv_pkg::EBAL_BITS-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vote_sum       <= '0;
      energy_balance <= '0;
      out_valid      <= 1'b0;
    end else if (en) begin
      out_valid <= rec.valid && rec.last_frame;
      if (rec.valid) begin
        if (rec.last_frame) begin
          vote_sum       <= '0;
          energy_balance <= '0;
        end else begin
          vote_sum       <= vote_next;
          energy_balance <= ebal_next;
        end
      end
    end
    if (en && rec.valid && rec.last_frame) begin
      inverted     <= neg_next;
      vote_total   <= vote_next;
      energy_total <= ebal_next;
    end
  end

`ifndef SYNTHESIS
  a_segment_clear: assert property (@(posedge clk) disable iff (rst)
    (en && rec.valid && rec.last_frame) |=> (vote_sum == '0 && energy_balance == '0))
    else $error("segment sums not cleared after result");

  a_decision: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (inverted == (vote_total[hpv_pkg::VOTE_BITS-1] ||
                                (vote_total == '0 && energy_total[hpv_pkg::EBAL_BITS-1]))))
    else $error("polarity flag disagrees with totals");
`endif

endmodule

`default_nettype wire

FILE: rtl/harmonic_polarity_vote_top.sv
// Harmonic polarity vote: decides speech polarity from harmonic phases.
// Input channel (in_valid/in_ready) carries one harmonic per beat: amplitude,
// phase (65536 = one turn), voiced, last_harmonic and last_frame. Frames end
// on last_harmonic; the frame that also carries last_frame ends the segment.
// Output channel (out_valid/out_ready) carries one beat per segment, raised
// by the closing harmonic: inverted (1 = add half a turn to voiced phases),
// vote_total and energy_total, both saturated signed sums.
// Throughput is one beat per cycle while the receiver does not stall. The
// pipeline is an input register, a squaring register, a frame accumulator
// stage and the result register, which a closing beat passes in that order.
// The whole pipeline advances together whenever the result register is
// empty or being taken; when the receiver stalls with a result pending,
// in_ready drops and every stage holds. Beats that cause no result never
// occupy the result register.
// Synchronous reset clears all valid flags, the frame accumulators and the
// segment sums; no clearing pass is needed afterward.
`default_nettype none

module harmonic_polarity_vote_top (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic [hpv_pkg::AMP_BITS-1:0]             amplitude,
  input  wire logic signed [hpv_pkg::PHASE_IN_BITS-1:0] phase,
  input  wire logic                                     voiced,
  input  wire logic                                     last_harmonic,
  input  wire logic                                     last_frame,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic                                          inverted,
  output logic signed [hpv_pkg::VOTE_BITS-1:0]          vote_total,
  output logic signed [hpv_pkg::EBAL_BITS-1:0]          energy_total
);

  // Global advance: the result register is free or is being emptied.
  logic                en;
  logic                s0_valid;
  hpv_pkg::item_t      s0;
  hpv_pkg::frame_rec_t rec;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Input register: captures the accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
    if (en && in_valid) begin
      s0.amplitude     <= amplitude;
      s0.phase         <= phase;
      s0.voiced        <= voiced;
      s0.last_harmonic <= last_harmonic;
      s0.last_frame    <= last_frame;
    end
  end

  hpv_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .item_valid (s0_valid),
    .item       (s0),
    .rec        (rec)
  );

  hpv_segment u_segment (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .rec          (rec),
    .out_valid    (out_valid),
    .inverted     (inverted),
    .vote_total   (vote_total),
    .energy_total (energy_total)
  );

endmodule

`default_nettype wire
